// ===== hw/rtl/lottery_scheduler_unit_assert.svh =====
// Assertion macros for the lottery scheduler unit.
`ifndef LOTTERY_SCHEDULER_UNIT_ASSERT_SVH
`define LOTTERY_SCHEDULER_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define LSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lottery_scheduler_unit: same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define LSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lottery_scheduler_unit: next-cycle check failed");

`endif

// ===== hw/rtl/lsu_pkg.sv =====
// Shared constants, codes and types of the lottery scheduler unit.
package lsu_pkg;

  // Table geometry
  localparam int unsigned MaxTasks   = 16;
  localparam int unsigned TicketBits = 10;
  localparam int unsigned CountW     = $clog2(MaxTasks + 1);
  localparam int unsigned TotalW     = $clog2(MaxTasks * ((1 << TicketBits) - 1) + 1);

  // Port field widths
  localparam int unsigned OpW        = 2;
  localparam int unsigned IdW        = 8;
  localparam int unsigned TicketInW  = 10;
  localparam int unsigned RandW      = 32;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned TotalOutW  = 14;
  localparam int unsigned CountOutW  = 5;

  // Modulo unit step counter
  localparam int unsigned StepW      = $clog2(RandW + 1);

  typedef enum logic [OpW-1:0] {
    OpAdd    = OpW'(0),
    OpRemove = OpW'(1),
    OpPick   = OpW'(2)
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk     = StatusW'(0),
    StFull   = StatusW'(1),
    StAbsent = StatusW'(2),
    StEmpty  = StatusW'(3)
  } status_e;

  typedef enum logic [1:0] {
    StateIdle,
    StateDivide,
    StateScan,
    StateFinish
  } state_e;

  // Token that walks the row of cells, one cell per cycle
  typedef struct packed {
    logic                  active;
    logic                  pick;
    logic [IdW-1:0]        key;
    logic                  found;
    logic [TicketBits-1:0] removed_tk;
    logic [TotalW-1:0]     residual;
    logic [IdW-1:0]        winner;
  } token_t;

endpackage

// ===== hw/rtl/lottery_scheduler_unit.sv =====
// Top level of the lottery scheduler unit: control, totals and the cell row.
//
//   channel  direction  handshake                    fields
//   request  in         in_valid_i / in_stall_o      operation, task_id, ticket_count, random_value
//   result   out        out_valid_o / out_stall_i    status, winner_id, ticket_total, task_count
//
// An add, a full-table add, an empty pick and an unused code go straight to the finish state.
// A remove goes to the scan state: the search token walks the whole cell row.
// A pick runs the bit-serial modulo unit first, then sends the token through the row.
// One request is in work at a time; the next is taken while a result waits in the
// output register. Reset empties the table at once; no clearing pass is needed.
module lottery_scheduler_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lsu_pkg::OpW-1:0]       operation_i,
  input  logic [lsu_pkg::IdW-1:0]       task_id_i,
  input  logic [lsu_pkg::TicketInW-1:0] ticket_count_i,
  input  logic [lsu_pkg::RandW-1:0]     random_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lsu_pkg::StatusW-1:0]   status_o,
  output logic [lsu_pkg::IdW-1:0]       winner_id_o,
  output logic [lsu_pkg::TotalOutW-1:0] ticket_total_o,
  output logic [lsu_pkg::CountOutW-1:0] task_count_o
);
  import lsu_pkg::*;

  state_e                state_q, state_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [TotalW-1:0]     total_q, total_d;
  status_e               res_status_q, res_status_d;
  logic [IdW-1:0]        res_winner_q, res_winner_d;
  logic                  out_valid_q, out_load;
  logic [StatusW-1:0]    out_status_q;
  logic [IdW-1:0]        out_winner_q;
  logic [TotalOutW-1:0]  out_total_q;
  logic [CountOutW-1:0]  out_count_q;
  logic                  in_acc, add_load, mod_start, mod_done;
  logic [TotalW-1:0]     mod_rem;
  logic [TicketBits-1:0] in_tk;
  token_t                inj, tail;
  token_t                chain [MaxTasks+1];
  logic [IdW-1:0]        cell_id [MaxTasks];
  logic [TicketBits-1:0] cell_tk [MaxTasks];

  assign in_stall_o = (state_q != StateIdle);
  assign in_acc     = in_valid_i && (state_q == StateIdle);
  assign in_tk      = TicketBits'(ticket_count_i);
  assign tail       = chain[MaxTasks];
  assign chain[0]   = inj;

  // Sequencer: next state, table totals and pending result
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    total_d      = total_q;
    res_status_d = res_status_q;
    res_winner_d = res_winner_q;
    add_load     = 1'b0;
    mod_start    = 1'b0;
    out_load     = 1'b0;
    inj          = '0;
    unique case (state_q)
      StateIdle: begin
        if (in_acc) begin
          res_status_d = StOk;
          res_winner_d = '0;
          state_d      = StateFinish;
          unique case (op_e'(operation_i))
            OpAdd: begin
              if (count_q == CountW'(MaxTasks)) begin
                res_status_d = StFull;
              end else begin
                add_load = 1'b1;
                count_d  = count_q + CountW'(1);
                total_d  = total_q + TotalW'(in_tk);
              end
            end
            OpRemove: begin
              inj.active = 1'b1;
              inj.key    = task_id_i;
              state_d    = StateScan;
            end
            OpPick: begin
              if (total_q == '0) begin
                res_status_d = StEmpty;
              end else begin
                mod_start = 1'b1;
                state_d   = StateDivide;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StateDivide: begin
        if (mod_done) begin
          inj.active   = 1'b1;
          inj.pick     = 1'b1;
          inj.residual = mod_rem;
          state_d      = StateScan;
        end
      end
      StateScan: begin
        if (tail.active) begin
          state_d = StateFinish;
          if (!tail.found) begin
            res_status_d = tail.pick ? StEmpty : StAbsent;
          end else if (tail.pick) begin
            res_winner_d = tail.winner;
          end else begin
            count_d = count_q - CountW'(1);
            total_d = total_q - TotalW'(tail.removed_tk);
          end
        end
      end
      StateFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = StateIdle;
        end
      end
      default: state_d = StateIdle;
    endcase
  end

  // Control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StateIdle;
      count_q      <= '0;
      total_q      <= '0;
      res_status_q <= StOk;
      res_winner_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      total_q      <= total_d;
      res_status_q <= res_status_d;
      res_winner_q <= res_winner_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_winner_q <= res_winner_q;
      out_total_q  <= TotalOutW'(total_q);
      out_count_q  <= CountOutW'(count_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign winner_id_o    = out_winner_q;
  assign ticket_total_o = out_total_q;
  assign task_count_o   = out_count_q;

  // Reduce the draw modulo the ticket total
  lsu_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (random_value_i),
    .divisor_i  (total_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Row of table cells, token flowing from slot zero upward
  for (genvar k = 0; k < MaxTasks; k++) begin : g_cell
    logic [IdW-1:0]        nxt_id;
    logic [TicketBits-1:0] nxt_tk;

    if (k == MaxTasks - 1) begin : g_last
      assign nxt_id = cell_id[k];
      assign nxt_tk = cell_tk[k];
    end else begin : g_mid
      assign nxt_id = cell_id[k+1];
      assign nxt_tk = cell_tk[k+1];
    end

    lsu_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .live_i    (CountW'(k) < count_q),
      .load_i    (add_load && (count_q == CountW'(k))),
      .load_id_i (task_id_i),
      .load_tk_i (in_tk),
      .nxt_id_i  (nxt_id),
      .nxt_tk_i  (nxt_tk),
      .token_i   (chain[k]),
      .token_o   (chain[k+1]),
      .id_o      (cell_id[k]),
      .tk_o      (cell_tk[k])
    );
  end

  `include "lottery_scheduler_unit_assert.svh"

  `LSU_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CountW'(MaxTasks))
  `LSU_ASSERT_NOW(a_empty_total, count_q == '0, total_q == '0)
  `LSU_ASSERT_NOW(a_mod_in_divide, mod_done, state_q == StateDivide)
  `LSU_ASSERT_NEXT(a_scan_ends, state_q == StateScan && tail.active, state_q == StateFinish)
  `LSU_ASSERT_NOW(a_winner_zero, out_valid_q && status_o != StOk, winner_id_o == '0)

endmodule

// ===== hw/rtl/lsu_cell.sv =====
// One table slot: holds a task and processes the passing search token.
module lsu_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          live_i,
  input  logic                          load_i,
  input  logic [lsu_pkg::IdW-1:0]        load_id_i,
  input  logic [lsu_pkg::TicketBits-1:0] load_tk_i,
  input  logic [lsu_pkg::IdW-1:0]        nxt_id_i,
  input  logic [lsu_pkg::TicketBits-1:0] nxt_tk_i,
  input  lsu_pkg::token_t               token_i,
  output lsu_pkg::token_t               token_o,
  output logic [lsu_pkg::IdW-1:0]        id_o,
  output logic [lsu_pkg::TicketBits-1:0] tk_o
);
  import lsu_pkg::*;

  logic [IdW-1:0]        id_q, id_d;
  logic [TicketBits-1:0] tk_q, tk_d;
  token_t                tok_q, tok_d;
  logic                  work, match, hit, shift;

  // Search, remove, pick and append step for this slot
  always_comb begin
    tok_d = token_i;
    id_d  = id_q;
    tk_d  = tk_q;
    work  = token_i.active && live_i && !token_i.found;
    match = work && !token_i.pick && (id_q == token_i.key);
    hit   = work && token_i.pick && (token_i.residual < TotalW'(tk_q));
    shift = token_i.active && live_i && !token_i.pick && (token_i.found || match);

    // Mark the first matching task and remember its tickets
    if (match) begin
      tok_d.found      = 1'b1;
      tok_d.removed_tk = tk_q;
    end

    // Claim the draw if it falls in this range, else advance past it
    if (hit) begin
      tok_d.found  = 1'b1;
      tok_d.winner = id_q;
    end else if (work && token_i.pick) begin
      tok_d.residual = token_i.residual - TotalW'(tk_q);
    end

    // Append a new task, or close the gap by taking the right neighbor
    if (load_i) begin
      id_d = load_id_i;
      tk_d = load_tk_i;
    end else if (shift) begin
      id_d = nxt_id_i;
      tk_d = nxt_tk_i;
    end
  end

  // Hand the token on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // Hold the slot contents
  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    tk_q <= tk_d;
  end

  assign token_o = tok_q;
  assign id_o    = id_q;
  assign tk_o    = tk_q;

endmodule

// ===== hw/rtl/lsu_mod.sv =====
// Bit-serial modulo unit: one dividend bit per cycle.
module lsu_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lsu_pkg::RandW-1:0]  dividend_i,
  input  logic [lsu_pkg::TotalW-1:0] divisor_i,
  output logic                      done_o,
  output logic [lsu_pkg::TotalW-1:0] rem_o
);
  import lsu_pkg::*;

  logic              busy_q, done_q;
  logic [StepW-1:0]  cnt_q;
  logic [RandW-1:0]  num_q;
  logic [TotalW-1:0] rem_q, rem_step;
  logic [TotalW:0]   trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_q, num_q[RandW-1]};
    if (trial >= {1'b0, divisor_i}) begin
      rem_step = TotalW'(trial - {1'b0, divisor_i});
    end else begin
      rem_step = trial[TotalW-1:0];
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= StepW'(RandW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - StepW'(1);
        if (cnt_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= rem_step;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
